@@ rtl/ctbt_pkg.sv @@
// Shared types and constants for the collision time brake trigger.
// Used by ctbt_core and collision_time_brake_trigger; depends on nothing.
package ctbt_pkg;

  localparam int unsigned SpeedW   = 24;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned GapW     = 24;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned QuoW     = TimeW + 1;
  localparam int unsigned CntW     = $clog2(QuoW);
  localparam int unsigned UnitW    = SpeedW + 2;
  localparam int unsigned PaddrW   = 3;

  localparam logic [TimeW-1:0] ThrMin   = 16'd256;
  localparam logic [TimeW-1:0] ThrReset = 16'd1280;

  // Register index of the threshold register (byte address 4 * index).
  localparam logic [0:0] RegThreshold = 1'b0;

  typedef enum logic [1:0] {
    FUNC_SPEED = 2'd0,
    FUNC_LIMIT = 2'd1,
    FUNC_CAR   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [SpeedW-1:0]  velocity;
    logic [LimitW-1:0]  limit_value;
    logic [GapW-1:0]    gap_distance;
  } item_t;

  typedef struct packed {
    logic               brake_issued;
    logic [TimeW-1:0]   collision_time;
    logic [SpeedW-1:0]  current_speed;
    logic [LimitW-1:0]  current_limit;
  } result_t;

endpackage

@@ rtl/ctbt_core.sv @@
// Event sequencer and datapath of the collision time brake trigger.
// One shared 26-bit subtractor serves the limit test, the relative speed,
// the overflow check and every step of the restoring divider. Uses ctbt_pkg.
module ctbt_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  ctbt_pkg::item_t              item_i,
  input  logic [ctbt_pkg::TimeW-1:0]   thr_i,
  input  logic                         out_free_i,
  output logic                         ready_o,
  output logic                         done_o,
  output ctbt_pkg::result_t            res_o
);

  ctbt_pkg::state_e                    state_q, state_d;
  ctbt_pkg::item_t                     item_q;
  logic [ctbt_pkg::SpeedW-1:0]         own_q, own_d;
  logic [ctbt_pkg::LimitW-1:0]         lim_q, lim_d;
  logic [ctbt_pkg::SpeedW-1:0]         den_q, den_d;
  logic [ctbt_pkg::SpeedW-1:0]         rem_q, rem_d;
  logic [ctbt_pkg::QuoW-1:0]           num_q, num_d;
  logic [ctbt_pkg::QuoW-1:0]           quo_q, quo_d;
  logic [ctbt_pkg::CntW-1:0]           cnt_q, cnt_d;
  logic                                brake_q, brake_d;
  logic                                div_ok_q, div_ok_d;

  logic signed [ctbt_pkg::UnitW-1:0]   unit_a, unit_b, unit_diff;
  logic                                unit_neg;
  logic [ctbt_pkg::QuoW-1:0]           thr_eff;
  logic                                ttc_brake;

  // Shared subtract unit with its operand selection.
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      ctbt_pkg::ST_EXEC: begin
        unit_a = {{2{own_q[ctbt_pkg::SpeedW-1]}}, own_q};
        if (item_q.func == ctbt_pkg::FUNC_LIMIT) begin
          unit_b = {2'b00, item_q.limit_value, 8'h00};
        end else begin
          unit_b = {{2{item_q.velocity[ctbt_pkg::SpeedW-1]}}, item_q.velocity};
        end
      end
      ctbt_pkg::ST_CHECK: begin
        unit_a = {2'b00, rem_q};
        unit_b = {2'b00, den_q};
      end
      ctbt_pkg::ST_DIV: begin
        unit_a = {1'b0, rem_q, num_q[ctbt_pkg::QuoW-1]};
        unit_b = {2'b00, den_q};
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff = unit_a - unit_b;
  assign unit_neg  = unit_diff[ctbt_pkg::UnitW-1];

  // Thresholds below one second act as one second.
  assign thr_eff = (thr_i < ctbt_pkg::ThrMin) ? {1'b0, ctbt_pkg::ThrMin} : {1'b0, thr_i};

  // The exact quotient is at or under the threshold when the truncated one is
  // below it, or equal to it with nothing left over.
  assign ttc_brake = div_ok_q &&
                     ((quo_q < thr_eff) || ((quo_q == thr_eff) && (rem_q == '0)));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ctbt_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = ctbt_pkg::ST_EXEC;
        end
      end
      ctbt_pkg::ST_EXEC: begin
        if (item_q.func == ctbt_pkg::FUNC_CAR && item_q.gap_distance != '0 &&
            !unit_neg && unit_diff != '0) begin
          state_d = ctbt_pkg::ST_CHECK;
        end else begin
          state_d = ctbt_pkg::ST_FINISH;
        end
      end
      ctbt_pkg::ST_CHECK: begin
        state_d = unit_neg ? ctbt_pkg::ST_DIV : ctbt_pkg::ST_FINISH;
      end
      ctbt_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ctbt_pkg::ST_FINISH;
        end
      end
      ctbt_pkg::ST_FINISH: begin
        if (out_free_i) begin
          state_d = ctbt_pkg::ST_IDLE;
        end
      end
      default: state_d = ctbt_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    own_d    = own_q;
    lim_d    = lim_q;
    den_d    = den_q;
    rem_d    = rem_q;
    num_d    = num_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    brake_d  = brake_q;
    div_ok_d = div_ok_q;
    case (state_q)
      ctbt_pkg::ST_IDLE: begin
        brake_d  = 1'b0;
        div_ok_d = 1'b0;
      end
      ctbt_pkg::ST_EXEC: begin
        case (item_q.func)
          ctbt_pkg::FUNC_SPEED: own_d = item_q.velocity;
          ctbt_pkg::FUNC_LIMIT: begin
            lim_d   = item_q.limit_value;
            brake_d = !unit_neg && (unit_diff != '0);
          end
          ctbt_pkg::FUNC_CAR: begin
            // Numerator is gap * 256; its top 15 bits seed the remainder.
            den_d = unit_diff[ctbt_pkg::SpeedW-1:0];
            rem_d = {{(ctbt_pkg::SpeedW-15){1'b0}}, item_q.gap_distance[23:9]};
            num_d = {item_q.gap_distance[8:0], 8'h00};
            quo_d = '0;
          end
          default: ;
        endcase
      end
      ctbt_pkg::ST_CHECK: begin
        // A top part at or above the divisor means a quotient of 2^17 or more.
        cnt_d = ctbt_pkg::CntW'(ctbt_pkg::QuoW - 1);
      end
      ctbt_pkg::ST_DIV: begin
        if (!unit_neg) begin
          rem_d = unit_diff[ctbt_pkg::SpeedW-1:0];
        end else begin
          rem_d = {rem_q[ctbt_pkg::SpeedW-2:0], num_q[ctbt_pkg::QuoW-1]};
        end
        quo_d = {quo_q[ctbt_pkg::QuoW-2:0], !unit_neg};
        num_d = {num_q[ctbt_pkg::QuoW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          div_ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ctbt_pkg::ST_IDLE;
      own_q    <= '0;
      lim_q    <= '0;
      cnt_q    <= '0;
      brake_q  <= 1'b0;
      div_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      own_q    <= own_d;
      lim_q    <= lim_d;
      cnt_q    <= cnt_d;
      brake_q  <= brake_d;
      div_ok_q <= div_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ctbt_pkg::ST_IDLE && start_i) begin
      item_q <= item_i;
    end
    den_q <= den_d;
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  // Outputs.
  always_comb begin
    ready_o = (state_q == ctbt_pkg::ST_IDLE);
    done_o  = (state_q == ctbt_pkg::ST_FINISH) && out_free_i;
    res_o.brake_issued   = brake_q || ttc_brake;
    res_o.collision_time = ttc_brake ? quo_q[ctbt_pkg::TimeW-1:0] : '0;
    res_o.current_speed  = own_q;
    res_o.current_limit  = lim_q;
  end

endmodule

@@ rtl/collision_time_brake_trigger.sv @@
// Top level of the collision time brake trigger: stream ports, the APB
// threshold register and the result register. Uses ctbt_pkg and ctbt_core.
//
// Events enter on the s_axis channel, one word per event; s_axis_tuser selects
// the kind (own speed, speed limit, car detected). Every event yields exactly
// one result word on m_axis: the brake flag in m_axis_tuser, the time to
// collision and the stored speed and limit in m_axis_tdata.
// An own speed update, a speed limit event or an unused selector goes from the
// execute state to the finish state, which hands it to the result register.
// A car detected event runs a restoring divider of 17 quotient bits through
// the shared subtractor after an overflow check; gaps or speeds that rule out
// braking end early. The block takes one event at a time: s_axis_tready is
// high only while the sequencer is idle.
// A finished result waits in the output register; a new event may be accepted
// meanwhile, and its result is held in the sequencer until the register frees.
// Reset clears the stored speed and limit to zero, empties the output register
// and sets the threshold to 1280 (5 s). The threshold is written over APB at
// address 0; the user must do so only while no event is in flight, as the block
// does not enforce it. Values under 256 act as 256.
module collision_time_brake_trigger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [23:0] velocity, [39:24] limit_value, [63:40] gap_distance
  input  logic [63:0]                   s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] collision_time, [39:16] current_speed, [55:40] current_limit
  output logic [55:0]                   m_axis_tdata,
  // [0] brake_issued
  output logic [0:0]                    m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctbt_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [ctbt_pkg::TimeW-1:0] thr_q;
  logic                       out_valid_q;
  ctbt_pkg::result_t          out_res_q;
  ctbt_pkg::item_t            item;
  ctbt_pkg::result_t          core_res;
  logic                       core_ready, core_done, out_free, in_word, reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ctbt_pkg::RegThreshold);
  assign prdata  = reg_sel ? {16'h0000, thr_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ctbt_pkg::ThrReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr_q <= pwdata[ctbt_pkg::TimeW-1:0];
    end
  end

  assign item.func         = ctbt_pkg::func_e'(s_axis_tuser);
  assign item.velocity     = s_axis_tdata[23:0];
  assign item.limit_value  = s_axis_tdata[39:24];
  assign item.gap_distance = s_axis_tdata[63:40];

  assign s_axis_tready = core_ready;
  assign in_word       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  ctbt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_word),
    .item_i     (item),
    .thr_i      (thr_q),
    .out_free_i (out_free),
    .ready_o    (core_ready),
    .done_o     (core_done),
    .res_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.brake_issued;
  assign m_axis_tdata  = {out_res_q.current_limit, out_res_q.current_speed,
                          out_res_q.collision_time};

  // A result without a brake carries a zero time.
  a_no_brake_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == '0)
    else $error("result without brake carries a nonzero time");

  // The sequencer never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !out_valid_q || m_axis_tready)
    else $error("result register overwritten while occupied");

  // An accepted word starts the sequencer, which then stops taking words.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word |=> !s_axis_tready)
    else $error("input still ready right after a word was accepted");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the collision time brake trigger.
// Depends on ctbt_pkg and collision_time_brake_trigger; drives both stream
// channels and the APB threshold port and checks every result word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [ctbt_pkg::PaddrW-1:0] ThresholdAddr = {ctbt_pkg::RegThreshold, 2'b00};

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic s_valid = 1'b0;
  logic [63:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_ready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ctbt_pkg::PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor state, kept in step with the block at each accepted word.
  logic [ctbt_pkg::SpeedW-1:0] own_speed_q = '0;
  logic [ctbt_pkg::LimitW-1:0] posted_limit_q = '0;
  logic [ctbt_pkg::TimeW-1:0] threshold_q = ctbt_pkg::ThrReset;

  ctbt_pkg::result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned brakes_seen = 0;
  int unsigned settings_used = 1;
  int unsigned burst_left = 0;
  bit no_gaps = 1'b0;

  // Receiver stall pattern and the long hold-off requested by the test.
  int unsigned cycle_count = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;

  collision_time_brake_trigger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic ctbt_pkg::result_t predict_brake(input logic [1:0] f,
                                            input logic [ctbt_pkg::SpeedW-1:0] vel,
                                            input logic [ctbt_pkg::LimitW-1:0] lim,
                                            input logic [ctbt_pkg::GapW-1:0] gap);
    ctbt_pkg::result_t r;
    longint rel;
    longint num;
    longint thr;
    r = '0;
    case (f)
      ctbt_pkg::FUNC_SPEED: own_speed_q = vel;
      ctbt_pkg::FUNC_LIMIT: begin
        posted_limit_q = lim;
        // Equal to the limit is not over it.
        if (longint'($signed(own_speed_q)) > longint'(lim) * 256) r.brake_issued = 1'b1;
      end
      ctbt_pkg::FUNC_CAR: begin
        rel = longint'($signed(own_speed_q)) - longint'($signed(vel));
        thr = (threshold_q < ctbt_pkg::ThrMin) ? longint'(ctbt_pkg::ThrMin) :
                                                 longint'(threshold_q);
        if (gap != '0 && rel > 0) begin
          num = longint'(gap) << 8;
          // The comparison uses the exact quotient, the reported time is truncated.
          if (num <= thr * rel) begin
            r.brake_issued = 1'b1;
            r.collision_time = ctbt_pkg::TimeW'(num / rel);
          end
        end
      end
      default: ;
    endcase
    r.current_speed = own_speed_q;
    r.current_limit = posted_limit_q;
    return r;
  endfunction

  task automatic send_event(input logic [1:0] f, input logic [ctbt_pkg::SpeedW-1:0] vel,
                            input logic [ctbt_pkg::LimitW-1:0] lim,
                            input logic [ctbt_pkg::GapW-1:0] gap);
    int unsigned idle;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (idle != 0) begin
        s_valid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    s_valid <= 1'b1;
    s_user <= f;
    s_data <= {gap, lim, vel};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_brake(f, vel, lim, gap));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [ctbt_pkg::TimeW-1:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ThresholdAddr;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    threshold_q = value;
    settings_used++;
    @(posedge clk_i);
  endtask

  // Speed updates, limit events and the unused selector at their extremes.
  task automatic test_speed_and_limit();
    send_event(FuncUnused, 24'h123456, 16'hABCD, 24'h654321);
    send_event(ctbt_pkg::FUNC_SPEED, 24'h7FFFFF, '0, '0);
    send_event(ctbt_pkg::FUNC_LIMIT, '0, 16'd0, '0);
    send_event(ctbt_pkg::FUNC_LIMIT, '0, 16'd32767, '0);
    send_event(ctbt_pkg::FUNC_LIMIT, '0, 16'd32768, '0);
    send_event(ctbt_pkg::FUNC_LIMIT, '0, 16'hFFFF, '0);
    send_event(ctbt_pkg::FUNC_SPEED, 24'h800000, '0, '0);
    send_event(ctbt_pkg::FUNC_LIMIT, '0, 16'd0, '0);
    send_event(ctbt_pkg::FUNC_SPEED, 24'd25600, '0, '0);
    send_event(ctbt_pkg::FUNC_LIMIT, 24'hFFFFFF, 16'd100, 24'hFFFFFF);
    send_event(ctbt_pkg::FUNC_LIMIT, '0, 16'd99, '0);
    send_event(FuncUnused, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
  endtask

  // Car events around the gap, relative speed and threshold boundaries.
  task automatic test_car_edges();
    send_event(ctbt_pkg::FUNC_CAR, 24'd0, '0, 24'd0);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25600, '0, 24'd1000);
    send_event(ctbt_pkg::FUNC_CAR, 24'd30000, '0, 24'd1000);
    send_event(ctbt_pkg::FUNC_CAR, 24'h800000, '0, 24'd1);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25344, '0, 24'd1280);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25344, '0, 24'd1281);
    send_event(ctbt_pkg::FUNC_CAR, 24'h800000, '0, 24'hFFFFFF);
    send_event(ctbt_pkg::FUNC_SPEED, 24'h800000, '0, '0);
    send_event(ctbt_pkg::FUNC_CAR, 24'h7FFFFF, '0, 24'd500);
    send_event(ctbt_pkg::FUNC_SPEED, 24'd25600, '0, '0);
  endtask

  // Both ends of the threshold range and a value under the floor.
  task automatic test_threshold_edges();
    set_threshold(ctbt_pkg::ThrMin);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25344, '0, 24'd256);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25344, '0, 24'd257);
    set_threshold(16'hFFFF);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25599, '0, 24'd65535);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25599, '0, 24'd65536);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25599, '0, 24'hFFFFFF);
    set_threshold(16'd100);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25344, '0, 24'd256);
    send_event(ctbt_pkg::FUNC_CAR, 24'd25344, '0, 24'd257);
    set_threshold(ctbt_pkg::ThrReset);
  endtask

  task automatic test_random_traffic(input int n_items);
    int unsigned pick;
    longint rel;
    longint target;
    longint gap_l;
    longint thr;
    logic [1:0] f;
    logic [ctbt_pkg::SpeedW-1:0] vel;
    logic [ctbt_pkg::LimitW-1:0] lim;
    logic [ctbt_pkg::GapW-1:0] gap;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      f = ctbt_pkg::FUNC_CAR;
      vel = ctbt_pkg::SpeedW'($urandom);
      lim = ctbt_pkg::LimitW'($urandom);
      gap = ctbt_pkg::GapW'($urandom);
      thr = (threshold_q < ctbt_pkg::ThrMin) ? longint'(ctbt_pkg::ThrMin) :
                                               longint'(threshold_q);
      if (pick < 12) begin
        f = ctbt_pkg::FUNC_SPEED;
        if (pick < 8) vel = ctbt_pkg::SpeedW'($urandom_range(0, 20000));
        else if (pick < 10) vel = ctbt_pkg::SpeedW'($urandom_range(0, 80) * 256);
      end else if (pick < 27) begin
        f = ctbt_pkg::FUNC_LIMIT;
        if (pick < 23) begin
          lim = ctbt_pkg::LimitW'(longint'($signed(own_speed_q)) / 256 +
                                  longint'($urandom_range(0, 4)) - 2);
        end
      end else if (pick < 90) begin
        // Closing car with a gap placed around the threshold time.
        if (pick < 34) rel = longint'($urandom_range(0, 400)) - 300;
        else if (pick % 7 == 0) rel = longint'($urandom_range(1, 1 << 22));
        else rel = longint'($urandom_range(1, 4000));
        vel = ctbt_pkg::SpeedW'(longint'($signed(own_speed_q)) - rel);
        if (pick < 50) target = thr + longint'($urandom_range(0, 2)) - 1;
        else target = longint'($urandom_range(0, 2 * thr));
        if (rel > 0) gap_l = target * rel / 256 + longint'($urandom_range(0, 1));
        else gap_l = longint'($urandom_range(0, 5000));
        if (pick == 89) gap_l = 0;
        if (gap_l > 64'hFFFFFF) gap_l = 64'hFFFFFF;
        gap = ctbt_pkg::GapW'(gap_l);
      end else begin
        f = 2'($urandom);
      end
      send_event(f, vel, lim, gap);
    end
  endtask

  // The receiver holds off while words keep coming, so the block backs up.
  task automatic test_backpressure();
    hold_len <= 400;
    hold_seq <= hold_seq + 1;
    no_gaps = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_event(ctbt_pkg::FUNC_CAR, ctbt_pkg::SpeedW'($urandom_range(0, 25000)),
                 ctbt_pkg::LimitW'($urandom), ctbt_pkg::GapW'($urandom_range(0, 200000)));
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $error("run exceeded %0d cycles with %0d words outstanding", CycleLimit,
             pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    ctbt_pkg::result_t exp_r;
    if (rst_n && m_axis_tvalid && m_ready) begin
      results_seen++;
      if (m_axis_tuser[0]) brakes_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: tdata %h tuser %b", m_axis_tdata,
               m_axis_tuser);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser[0] !== exp_r.brake_issued) begin
          $error("brake_issued: expected %0d, actual %0d", exp_r.brake_issued, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tdata[15:0] !== exp_r.collision_time) begin
          $error("collision_time: expected %0d, actual %0d", exp_r.collision_time,
                 m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[39:16] !== exp_r.current_speed) begin
          $error("current_speed: expected %0d, actual %0d", $signed(exp_r.current_speed),
                 $signed(m_axis_tdata[39:16]));
          error_count++;
        end
        if (m_axis_tdata[55:40] !== exp_r.current_limit) begin
          $error("current_limit: expected %0d, actual %0d", exp_r.current_limit,
                 m_axis_tdata[55:40]);
          error_count++;
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= ($urandom_range(0, 9) < 7);
        2: m_ready <= ($urandom_range(0, 9) < 3);
        default: m_ready <= (cycle_count % 5 == 0);
      endcase
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_speed_and_limit();
    test_car_edges();
    test_threshold_edges();
    test_backpressure();
    test_random_traffic(200);
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_threshold(ctbt_pkg::ThrMin);
        1: set_threshold(16'hFFFF);
        default: set_threshold(ctbt_pkg::TimeW'($urandom_range(ctbt_pkg::ThrMin, 16'hFFFF)));
      endcase
      test_random_traffic(210);
    end
    wait_drained();
    $display("Sent %0d event words over %0d threshold settings.", items_sent, settings_used);
    $display("Checked %0d result words, %0d of them brake commands.", results_seen,
             brakes_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
